>>> rtl/qjet_pkg.sv
// ----------------------------------------------------------------------------
// qjet_pkg
// Shared constants and types of the quaternion Julia escape-time block:
// default widths, configuration register indexes and reset values.
// ----------------------------------------------------------------------------
package qjet_pkg;

  localparam int FRACTION_BITS_DEF   = 12;
  localparam int COMPONENT_WIDTH_DEF = 18;
  localparam int COUNT_WIDTH_DEF     = 10;

  localparam int CFG_INDEX_WIDTH = 3;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_C_REAL     = 3'd0,
    REG_C_I        = 3'd1,
    REG_C_J        = 3'd2,
    REG_C_K        = 3'd3,
    REG_ITER_LIMIT = 3'd4,
    REG_ESCAPE_R2  = 3'd5
  } cfg_reg_t;

  localparam int C_REAL_RST     = -3277;
  localparam int C_I_RST        = 639;
  localparam int C_J_RST        = 0;
  localparam int C_K_RST        = 0;
  localparam int ITER_LIMIT_RST = 64;
  localparam int ESCAPE_R2_RST  = 16384;

  localparam int QUEUE_DEPTH = 2;

endpackage

>>> rtl/qjet_in_if.sv
// ----------------------------------------------------------------------------
// qjet_in_if
// Input channel: one starting point per item, four signed components.
// ----------------------------------------------------------------------------
interface qjet_in_if import qjet_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic signed [COMPONENT_WIDTH-1:0] point_real;
  logic signed [COMPONENT_WIDTH-1:0] point_i;
  logic signed [COMPONENT_WIDTH-1:0] point_j;
  logic signed [COMPONENT_WIDTH-1:0] point_k;

  modport source (output valid, point_real, point_i, point_j, point_k, input ready);
  modport sink   (input valid, point_real, point_i, point_j, point_k, output ready);
endinterface

>>> rtl/qjet_out_if.sv
// ----------------------------------------------------------------------------
// qjet_out_if
// Result channel: iteration count and in-set flag, one item per point.
// ----------------------------------------------------------------------------
interface qjet_out_if import qjet_pkg::*; #(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [COUNT_WIDTH-1:0] iteration_count;
  logic                   in_set;

  modport source (output valid, iteration_count, in_set, input ready);
  modport sink   (input valid, iteration_count, in_set, output ready);
endinterface

>>> rtl/qjet_front.sv
// ----------------------------------------------------------------------------
// qjet_front
// Intake: accepts points, tags those that need no iteration at all, and
// packs them for the point queue.
// ----------------------------------------------------------------------------
module qjet_front import qjet_pkg::*; #(
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
  qjet_in_if.sink                   in_ch,
  input  logic [COUNT_WIDTH-1:0]    iter_limit,
  output logic                      push_valid,
  input  logic                      push_ready,
  output logic [4*COMPONENT_WIDTH:0] push_data
);

  logic limit_zero;

  assign limit_zero   = (iter_limit == '0);
  assign in_ch.ready  = push_ready;
  assign push_valid   = in_ch.valid;
  assign push_data    = {limit_zero, in_ch.point_k, in_ch.point_j, in_ch.point_i,
                         in_ch.point_real};

endmodule

>>> rtl/qjet_queue.sv
// ----------------------------------------------------------------------------
// qjet_queue
// Short first-in first-out queue of tagged points between intake and the
// iteration engine.
// ----------------------------------------------------------------------------
module qjet_queue import qjet_pkg::*; #(
  parameter int DATA_WIDTH = 4 * COMPONENT_WIDTH_DEF + 1,
  parameter int DEPTH      = QUEUE_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_valid,
  output logic                  push_ready,
  input  logic [DATA_WIDTH-1:0] push_data,
  output logic                  pop_valid,
  input  logic                  pop_ready,
  output logic [DATA_WIDTH-1:0] pop_data
);

  localparam int PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_WIDTH = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] slot_r [DEPTH];
  logic [PTR_WIDTH-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_WIDTH-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_WIDTH-1:0]  count_r, count_nxt;
  logic                  push, pop;

  assign push_ready = (count_r != CNT_WIDTH'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = slot_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_WIDTH'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_WIDTH'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_WIDTH'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_WIDTH'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_WIDTH'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/qjet_core.sv
// ----------------------------------------------------------------------------
// qjet_core
// Iteration engine: runs q <- q*q + c on one point at a time, each iteration
// a product state followed by an escape test and update state, and holds the
// result in an output register.
// ----------------------------------------------------------------------------
module qjet_core import qjet_pkg::*; #(
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              pop_valid,
  output logic                              pop_ready,
  input  logic [4*COMPONENT_WIDTH:0]        pop_data,
  input  logic signed [COMPONENT_WIDTH-1:0] c_real,
  input  logic signed [COMPONENT_WIDTH-1:0] c_i,
  input  logic signed [COMPONENT_WIDTH-1:0] c_j,
  input  logic signed [COMPONENT_WIDTH-1:0] c_k,
  input  logic [COUNT_WIDTH-1:0]            iter_limit,
  input  logic [COMPONENT_WIDTH-1:0]        escape_r2,
  qjet_out_if.source                        out_ch
);

  localparam int W    = COMPONENT_WIDTH;
  localparam int F    = FRACTION_BITS;
  localparam int PW   = 2 * W;
  localparam int SW   = 2 * W + 3;
  localparam int MAGW = (2 * W + 1 > W + F) ? 2 * W + 1 : W + F;

  localparam logic signed [SW-1:0] CMAX = $signed({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
  localparam logic signed [SW-1:0] CMIN = $signed({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_UPD  = 4'b0100,
    ST_FIN  = 4'b1000
  } core_state_t;

  core_state_t              state_r, state_nxt;
  logic signed [W-1:0]      q_r [4];
  logic signed [W-1:0]      q_nxt [4];
  logic signed [W-1:0]      c_vec [4];
  logic [PW-1:0]            sq_r [4];
  logic signed [PW-1:0]     sq_prod [4];
  logic signed [PW-1:0]     xp_r [1:3];
  logic signed [PW-1:0]     xp_prod [1:3];
  logic [COUNT_WIDTH-1:0]   n_r, n_nxt;
  logic                     set_r, set_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [COUNT_WIDTH-1:0]   out_cnt_r;
  logic                     out_set_r;
  logic                     out_load;
  logic [MAGW-1:0]          mag2;
  logic [MAGW-1:0]          thresh;
  logic                     escape;
  logic signed [SW-1:0]     diff;
  logic signed [SW-1:0]     upd_sum [4];

  function automatic logic signed [W-1:0] sat_comp(input logic signed [SW-1:0] v);
    logic signed [W-1:0] r;
    if (v > CMAX) begin
      r = CMAX[W-1:0];
    end else if (v < CMIN) begin
      r = CMIN[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  assign c_vec[0] = c_real;
  assign c_vec[1] = c_i;
  assign c_vec[2] = c_j;
  assign c_vec[3] = c_k;

  always_comb begin
    for (int m = 0; m < 4; m++) begin
      sq_prod[m] = q_r[m] * q_r[m];
    end
    for (int m = 1; m < 4; m++) begin
      xp_prod[m] = q_r[0] * q_r[m];
    end
  end

  assign mag2   = MAGW'(sq_r[0]) + MAGW'(sq_r[1]) + MAGW'(sq_r[2]) + MAGW'(sq_r[3]);
  assign thresh = MAGW'({escape_r2, {F{1'b0}}});
  assign escape = (mag2 > thresh);
  assign diff   = $signed(SW'(sq_r[0]))
                - $signed(SW'(sq_r[1]) + SW'(sq_r[2]) + SW'(sq_r[3]));

  always_comb begin
    upd_sum[0] = (diff >>> F) + SW'(c_vec[0]);
    for (int m = 1; m < 4; m++) begin
      upd_sum[m] = (SW'(xp_r[m]) >>> (F - 1)) + SW'(c_vec[m]);
    end
  end

  assign pop_ready = (state_r == ST_IDLE);
  assign out_load  = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    set_nxt   = set_r;
    for (int m = 0; m < 4; m++) begin
      q_nxt[m] = q_r[m];
    end
    unique case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          for (int m = 0; m < 4; m++) begin
            q_nxt[m] = $signed(pop_data[m*W +: W]);
          end
          n_nxt = '0;
          if (pop_data[4*W]) begin
            set_nxt   = 1'b1;
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        if (n_r >= iter_limit) begin
          set_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (escape) begin
          set_nxt   = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          for (int m = 0; m < 4; m++) begin
            q_nxt[m] = sat_comp(upd_sum[m]);
          end
          n_nxt     = n_r + COUNT_WIDTH'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    set_r <= set_nxt;
    for (int m = 0; m < 4; m++) begin
      q_r[m] <= q_nxt[m];
    end
    if (state_r == ST_MUL) begin
      for (int m = 0; m < 4; m++) begin
        sq_r[m] <= sq_prod[m];
      end
      for (int m = 1; m < 4; m++) begin
        xp_r[m] <= xp_prod[m];
      end
    end
    if (out_load) begin
      out_cnt_r <= n_r;
      out_set_r <= set_r;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.iteration_count = out_cnt_r;
  assign out_ch.in_set          = out_set_r;

endmodule

>>> rtl/quaternion_julia_escape_time_top.sv
// ----------------------------------------------------------------------------
// quaternion_julia_escape_time_top
// Quaternion Julia escape-time evaluator: one iteration count and in-set
// flag per 4D starting point, with c, the limit and the radius configurable.
// ----------------------------------------------------------------------------
// A point leaves the queue into the iteration engine, runs through its
// multiply and update states once per iteration, and passes to the output
// register when it reaches the limit or escapes; a point taken in with a zero
// limit goes straight to the output register. Each iteration is a state of
// seven parallel multiplies followed by a state of escape test, rounding, add
// and saturation in the iteration engine. Points are worked one at a time. A
// two-entry queue takes new points while the engine is busy, and the output
// register holds a finished result while the engine starts on the next point.
module quaternion_julia_escape_time_top import qjet_pkg::*; #(
  parameter int FRACTION_BITS   = FRACTION_BITS_DEF,
  parameter int COMPONENT_WIDTH = COMPONENT_WIDTH_DEF,
  parameter int COUNT_WIDTH     = COUNT_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [((COMPONENT_WIDTH > COUNT_WIDTH) ? COMPONENT_WIDTH : COUNT_WIDTH)-1:0]
                                     cfg_wdata,
  qjet_in_if.sink                    in_ch,
  qjet_out_if.source                 out_ch
);

  localparam int W          = COMPONENT_WIDTH;
  localparam int DATA_WIDTH = 4 * W + 1;

  logic signed [W-1:0]     c_real_r, c_i_r, c_j_r, c_k_r;
  logic [COUNT_WIDTH-1:0]  iter_limit_r;
  logic [W-1:0]            escape_r2_r;
  logic                    push_valid, push_ready;
  logic [DATA_WIDTH-1:0]   push_data;
  logic                    pop_valid, pop_ready;
  logic [DATA_WIDTH-1:0]   pop_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_real_r     <= W'(C_REAL_RST);
      c_i_r        <= W'(C_I_RST);
      c_j_r        <= W'(C_J_RST);
      c_k_r        <= W'(C_K_RST);
      iter_limit_r <= COUNT_WIDTH'(ITER_LIMIT_RST);
      escape_r2_r  <= W'(ESCAPE_R2_RST);
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_C_REAL:     c_real_r     <= $signed(cfg_wdata[W-1:0]);
        REG_C_I:        c_i_r        <= $signed(cfg_wdata[W-1:0]);
        REG_C_J:        c_j_r        <= $signed(cfg_wdata[W-1:0]);
        REG_C_K:        c_k_r        <= $signed(cfg_wdata[W-1:0]);
        REG_ITER_LIMIT: iter_limit_r <= cfg_wdata[COUNT_WIDTH-1:0];
        REG_ESCAPE_R2:  escape_r2_r  <= cfg_wdata[W-1:0];
        default: begin
        end
      endcase
    end
  end

  qjet_front #(
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_front (
    .in_ch      (in_ch),
    .iter_limit (iter_limit_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  qjet_queue #(
    .DATA_WIDTH (DATA_WIDTH),
    .DEPTH      (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  qjet_core #(
    .FRACTION_BITS   (FRACTION_BITS),
    .COMPONENT_WIDTH (COMPONENT_WIDTH),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data),
    .c_real     (c_real_r),
    .c_i        (c_i_r),
    .c_j        (c_j_r),
    .c_k        (c_k_r),
    .iter_limit (iter_limit_r),
    .escape_r2  (escape_r2_r),
    .out_ch     (out_ch)
  );

endmodule

>>> rtl/qjet_checker.sv
// ----------------------------------------------------------------------------
// qjet_checker
// Port-level checks of the escape-time block: result hold under stall,
// consistency of count and in-set flag with the programmed limit, and the
// number of items in flight.
// ----------------------------------------------------------------------------
module qjet_checker import qjet_pkg::*; #(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int CFG_DATA_WIDTH = COMPONENT_WIDTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       cfg_we,
  input logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input logic [CFG_DATA_WIDTH-1:0]  cfg_wdata,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [COUNT_WIDTH-1:0]     out_iteration_count,
  input logic                       out_in_set
);

  localparam int INFLIGHT_MAX   = QUEUE_DEPTH + 2;
  localparam int INFLIGHT_WIDTH = $clog2(INFLIGHT_MAX + 2);

  logic [COUNT_WIDTH-1:0]    limit_r;
  logic [INFLIGHT_WIDTH-1:0] inflight_r;
  logic                      in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r    <= COUNT_WIDTH'(ITER_LIMIT_RST);
      inflight_r <= '0;
    end else begin
      if (cfg_we && (cfg_reg_t'(cfg_index) == REG_ITER_LIMIT)) begin
        limit_r <= cfg_wdata[COUNT_WIDTH-1:0];
      end
      if (in_acc && !out_acc) begin
        inflight_r <= inflight_r + INFLIGHT_WIDTH'(1);
      end else if (out_acc && !in_acc) begin
        inflight_r <= inflight_r - INFLIGHT_WIDTH'(1);
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_iteration_count)
                                && $stable(out_in_set))
    else $error("result changed or dropped while stalled");

  a_in_set_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_in_set |-> out_iteration_count == limit_r)
    else $error("in-set result with count other than the limit");

  a_escaped_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_in_set |-> out_iteration_count < limit_r)
    else $error("escaped result with count at or above the limit");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != '0)
    else $error("result shown with no item in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    inflight_r <= INFLIGHT_WIDTH'(INFLIGHT_MAX))
    else $error("more items in flight than the block can hold");

endmodule

bind quaternion_julia_escape_time_top qjet_checker #(
  .COUNT_WIDTH    (COUNT_WIDTH),
  .CFG_DATA_WIDTH ((COMPONENT_WIDTH > COUNT_WIDTH) ? COMPONENT_WIDTH : COUNT_WIDTH)
) u_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .cfg_we              (cfg_we),
  .cfg_index           (cfg_index),
  .cfg_wdata           (cfg_wdata),
  .in_valid            (in_ch.valid),
  .in_ready            (in_ch.ready),
  .out_valid           (out_ch.valid),
  .out_ready           (out_ch.ready),
  .out_iteration_count (out_ch.iteration_count),
  .out_in_set          (out_ch.in_set)
);

>>> tb/tb_quaternion_julia_escape_time_top.sv
// ----------------------------------------------------------------------------
// tb_quaternion_julia_escape_time_top
// Self-checking bench for the quaternion Julia escape-time block. Points are
// sent over the input channel with random gaps, and results are taken with
// random stalls. A scoreboard class predicts the iteration count and in-set
// flag of every accepted point from its own copy of the configuration and
// compares them with each result in order. A directed part covers component
// extremes, the escape boundary, saturation, a zero limit, a zero radius and
// the largest count. Random phases with fresh configurations follow.
// ----------------------------------------------------------------------------
module tb_quaternion_julia_escape_time_top;
  import qjet_pkg::*;

  localparam int F          = FRACTION_BITS_DEF;
  localparam int W          = COMPONENT_WIDTH_DEF;
  localparam int CW         = COUNT_WIDTH_DEF;
  localparam int DW         = (W > CW) ? W : CW;
  localparam int MAX_CYCLES = 1_000_000;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 80;

  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SPARE_7 = 3'd7;

  localparam int COMP_MAX = (1 << (W - 1)) - 1;
  localparam int COMP_MIN = -(1 << (W - 1));

  typedef logic signed [W-1:0] comp_t;
  typedef logic [CW-1:0]       count_t;
  typedef logic [W-1:0]        r2_t;
  typedef logic [DW-1:0]       wdata_t;

  typedef struct packed {
    comp_t re;
    comp_t im_i;
    comp_t im_j;
    comp_t im_k;
  } point_t;

  typedef struct packed {
    count_t count;
    logic   in_set;
  } escape_t;

  typedef struct packed {
    comp_t  c_real;
    comp_t  c_i;
    comp_t  c_j;
    comp_t  c_k;
    count_t limit;
    r2_t    r2;
  } julia_cfg_t;

  class escape_count_board;
    julia_cfg_t regs;
    escape_t    awaited[$];
    int         errors;

    function new();
      regs.c_real = comp_t'(C_REAL_RST);
      regs.c_i    = comp_t'(C_I_RST);
      regs.c_j    = comp_t'(C_J_RST);
      regs.c_k    = comp_t'(C_K_RST);
      regs.limit  = count_t'(ITER_LIMIT_RST);
      regs.r2     = r2_t'(ESCAPE_R2_RST);
      errors      = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_WIDTH-1:0] idx, wdata_t data);
      case (idx)
        REG_C_REAL:     regs.c_real = comp_t'(data[W-1:0]);
        REG_C_I:        regs.c_i    = comp_t'(data[W-1:0]);
        REG_C_J:        regs.c_j    = comp_t'(data[W-1:0]);
        REG_C_K:        regs.c_k    = comp_t'(data[W-1:0]);
        REG_ITER_LIMIT: regs.limit  = count_t'(data[CW-1:0]);
        REG_ESCAPE_R2:  regs.r2     = r2_t'(data[W-1:0]);
        default: ;
      endcase
    endfunction

    function longint clamp(longint v);
      if (v > longint'(COMP_MAX)) return longint'(COMP_MAX);
      if (v < longint'(COMP_MIN)) return longint'(COMP_MIN);
      return v;
    endfunction

    function escape_t escape_time(point_t p);
      longint      q[4];
      longint      nq[4];
      longint      cc[4];
      longint      sq[4];
      longint      mag;
      longint      mag2;
      longint      rest;
      longint      thresh;
      int unsigned n;
      bit          escaped;
      escape_t     r;
      q[0]    = longint'(p.re);
      q[1]    = longint'(p.im_i);
      q[2]    = longint'(p.im_j);
      q[3]    = longint'(p.im_k);
      cc[0]   = longint'(regs.c_real);
      cc[1]   = longint'(regs.c_i);
      cc[2]   = longint'(regs.c_j);
      cc[3]   = longint'(regs.c_k);
      thresh  = longint'({1'b0, regs.r2}) << F;
      n       = 0;
      escaped = 1'b0;
      while (!escaped && n < int'(regs.limit)) begin
        mag2 = 0;
        for (int c = 0; c < 4; c++) begin
          mag   = (q[c] < 0) ? -q[c] : q[c];
          sq[c] = mag * mag;
          mag2  = mag2 + sq[c];
        end
        if (mag2 > thresh) begin
          escaped = 1'b1;
        end else begin
          rest  = sq[1] + sq[2] + sq[3];
          nq[0] = clamp(((sq[0] - rest) >>> F) + cc[0]);
          for (int c = 1; c < 4; c++) begin
            nq[c] = clamp(((q[0] * q[c]) >>> (F - 1)) + cc[c]);
          end
          q = nq;
          n++;
        end
      end
      r.count  = count_t'(n);
      r.in_set = (n >= int'(regs.limit));
      return r;
    endfunction

    function void note_point(point_t p);
      awaited.insert(awaited.size(), escape_time(p));
    endfunction

    function void check_result(escape_t got);
      escape_t want;
      if (awaited.size() == 0) begin
        $error("result with no point pending: iteration_count=%0d in_set=%0d",
               got.count, got.in_set);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.count !== want.count) begin
        $error("iteration_count: expected %0d, got %0d", want.count, got.count);
        errors++;
      end
      if (got.in_set !== want.in_set) begin
        $error("in_set: expected %0d, got %0d", want.in_set, got.in_set);
        errors++;
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       cfg_we;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  wdata_t                     cfg_wdata;
  bit                         in_burst;
  bit                         out_burst;
  int unsigned                cycles;
  escape_count_board          sb;

  qjet_in_if  #(.COMPONENT_WIDTH(W)) in_ch ();
  qjet_out_if #(.COUNT_WIDTH(CW))    out_ch ();

  quaternion_julia_escape_time_top #(
    .FRACTION_BITS  (F),
    .COMPONENT_WIDTH(W),
    .COUNT_WIDTH    (CW)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic point_t mk_point(int re, int im_i, int im_j, int im_k);
    point_t p;
    p.re   = comp_t'(re);
    p.im_i = comp_t'(im_i);
    p.im_j = comp_t'(im_j);
    p.im_k = comp_t'(im_k);
    return p;
  endfunction

  function automatic julia_cfg_t mk_cfg(int cr, int ci, int cj, int ck, int lim, int r2);
    julia_cfg_t c;
    c.c_real = comp_t'(cr);
    c.c_i    = comp_t'(ci);
    c.c_j    = comp_t'(cj);
    c.c_k    = comp_t'(ck);
    c.limit  = count_t'(lim);
    c.r2     = r2_t'(r2);
    return c;
  endfunction

  function automatic comp_t draw_comp(int unsigned span);
    case ($urandom_range(0, 9))
      0:       return comp_t'($urandom);
      1:       return ($urandom_range(0, 1) == 1) ? comp_t'(COMP_MAX) : comp_t'(COMP_MIN);
      2:       return comp_t'(int'($urandom_range(0, 2)) - 1);
      default: return comp_t'(int'($urandom_range(0, 2 * span)) - int'(span));
    endcase
  endfunction

  function automatic point_t draw_point();
    point_t p;
    int unsigned span;
    span   = ($urandom_range(0, 2) == 0) ? 2048 : 8192;
    p.re   = draw_comp(span);
    p.im_i = draw_comp(span);
    p.im_j = draw_comp(span);
    p.im_k = draw_comp(span);
    return p;
  endfunction

  function automatic julia_cfg_t draw_config(bit wide);
    julia_cfg_t c;
    if (wide) begin
      c.c_real = comp_t'($urandom);
      c.c_i    = comp_t'($urandom);
      c.c_j    = comp_t'($urandom);
      c.c_k    = comp_t'($urandom);
      c.r2     = r2_t'($urandom);
    end else begin
      c.c_real = draw_comp(6144);
      c.c_i    = draw_comp(4096);
      c.c_j    = ($urandom_range(0, 2) == 0) ? comp_t'(0) : draw_comp(2048);
      c.c_k    = ($urandom_range(0, 2) == 0) ? comp_t'(0) : draw_comp(2048);
      case ($urandom_range(0, 5))
        0:       c.r2 = r2_t'($urandom);
        1:       c.r2 = r2_t'($urandom_range(4096, 65536));
        default: c.r2 = r2_t'(ESCAPE_R2_RST);
      endcase
    end
    c.limit = ($urandom_range(0, 3) == 0) ? count_t'($urandom_range(1, 8))
                                          : count_t'($urandom_range(16, 128));
    return c;
  endfunction

  task automatic cfg_put(logic [CFG_INDEX_WIDTH-1:0] idx, wdata_t data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic load_config(julia_cfg_t c);
    logic [31:0] junk;
    junk = $urandom;
    cfg_put(REG_C_REAL, wdata_t'(c.c_real));
    cfg_put(REG_C_I, wdata_t'(c.c_i));
    cfg_put(REG_C_J, wdata_t'(c.c_j));
    cfg_put(REG_C_K, wdata_t'(c.c_k));
    cfg_put(REG_ITER_LIMIT, wdata_t'({junk[DW-CW-1:0], c.limit}));
    cfg_put(REG_ESCAPE_R2, wdata_t'(c.r2));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_point(point_t p);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 29) == 0) in_burst = !in_burst;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.point_real <= p.re;
    in_ch.point_i    <= p.im_i;
    in_ch.point_j    <= p.im_j;
    in_ch.point_k    <= p.im_k;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_point(p);
  endtask

  task automatic wait_idle(int settle);
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  initial begin
    int   gap;
    escape_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = out_burst ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 29) == 0) out_burst = !out_burst;
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      got.count  = out_ch.iteration_count;
      got.in_set = out_ch.in_set;
      sb.check_result(got);
    end
  end

  initial begin
    sb = new();
    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_C_REAL;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.point_real <= '0;
    in_ch.point_i    <= '0;
    in_ch.point_j    <= '0;
    in_ch.point_k    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: extremes, the escape boundary and rounding of
    // negative products.
    send_point(mk_point(0, 0, 0, 0));
    send_point(mk_point(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_point(mk_point(COMP_MIN, COMP_MIN, COMP_MIN, COMP_MIN));
    send_point(mk_point(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN));
    send_point(mk_point(COMP_MIN, 0, 0, 0));
    send_point(mk_point(8192, 0, 0, 0));
    send_point(mk_point(8193, 0, 0, 0));
    send_point(mk_point(0, -8192, 0, 0));
    send_point(mk_point(4096, 4096, 4096, 4096));
    send_point(mk_point(-1, 1, -1, 1));
    send_point(mk_point(-4096, -2048, 2048, -1));
    send_point(mk_point(1000, -500, 300, -200));
    send_point(mk_point(0, 0, 0, -1));

    // A zero limit runs no iterations and reports the point as inside.
    wait_idle(4);
    load_config(mk_cfg(C_REAL_RST, C_I_RST, 0, 0, 0, ESCAPE_R2_RST));
    cfg_put(REG_SPARE_6, wdata_t'($urandom));
    cfg_put(REG_SPARE_7, wdata_t'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
    send_point(mk_point(COMP_MAX, COMP_MAX, COMP_MAX, COMP_MAX));
    send_point(mk_point(0, 0, 0, 0));

    // A zero radius lets only the origin through, for a single iteration.
    wait_idle(4);
    load_config(mk_cfg(0, 0, 0, 0, 1, 0));
    send_point(mk_point(0, 0, 0, 0));
    send_point(mk_point(1, 0, 0, 0));
    send_point(mk_point(0, 0, 0, COMP_MIN));

    // Extreme constants with the widest radius drive components into
    // saturation.
    wait_idle(4);
    load_config(mk_cfg(COMP_MAX, COMP_MIN, COMP_MAX, COMP_MIN, (1 << CW) - 1,
                       (1 << W) - 1));
    send_point(mk_point(0, 0, 0, 0));
    send_point(mk_point(16384, 0, 0, 0));
    send_point(mk_point(-16384, 16384, -16384, 16384));

    // Zero, one half and minus one settle at the fixed points zero and one and run to the largest count.
    wait_idle(4);
    load_config(mk_cfg(0, 0, 0, 0, (1 << CW) - 1, ESCAPE_R2_RST));
    send_point(mk_point(0, 0, 0, 0));
    send_point(mk_point(2048, 0, 0, 0));
    send_point(mk_point(-4096, 0, 0, 0));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle(4);
      load_config(draw_config(ph == 0));
      for (int n = 0; n < PHASE_LEN; n++) send_point(draw_point());
    end

    wait_idle(20);
    if (sb.pending() != 0) begin
      $error("%0d results never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
